### hdl/texture_swizzle_address_gen_macros.svh
// Assertion helpers for the swizzle address generator.
// Every property is sampled on clk and is off while arst_n is low.
`ifndef TEXTURE_SWIZZLE_ADDRESS_GEN_MACROS_SVH
`define TEXTURE_SWIZZLE_ADDRESS_GEN_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSAG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSAG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tsag_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsag_pkg;

	// Fixed field widths
	localparam int TEXEL_W    = 32;
	localparam int DEST_W     = 26;
	localparam int LOG2_W     = 4;
	localparam int BPT_W      = 3;
	localparam int CFG_DATA_W = 4;
	localparam int CFG_IDX_W  = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOG2 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER   = 2'd2;

	// Reset values of the registers
	localparam logic [LOG2_W-1:0] WIDTH_LOG2_RST  = 4'd8;
	localparam logic [LOG2_W-1:0] HEIGHT_LOG2_RST = 4'd8;
	localparam logic [BPT_W-1:0]  BYTES_PER_RST   = 3'd4;

	// Legal texel size range
	localparam logic [BPT_W-1:0] BYTES_PER_MIN = 3'd1;
	localparam logic [BPT_W-1:0] BYTES_PER_MAX = 3'd4;

endpackage

`default_nettype wire

### hdl/texture_swizzle_address_gen.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Signals                                      Dir  Word
// texel     texel_valid, texel_ready, texel_data         in   one source texel
// result    result_valid, result_ready, dest_address,    out  swizzled address + texel
//           texel_out, last_of_image
// config    cfg_we, cfg_index, cfg_data                  in   register write, no wait
//
// Takes one texel every cycle while results are taken; each taken texel loads the
// input register, then moves into the result register once it is free, and is valid there.
// The path between them is masks, variable shifts, three 26-bit adds and a
// 26 x 3 multiply by the texel size.
// Reset clears the column and row counters and loads the register defaults.
// A stalled result holds in the result register; the input register keeps
// taking a texel as long as the word ahead of it moves on.

module texture_swizzle_address_gen
	import tsag_pkg::*;
#(
	parameter int MAX_SIDE_LOG2 = 12
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data,
	input  wire                   texel_valid,
	output logic                  texel_ready,
	input  wire [TEXEL_W-1:0]     texel_data,
	output logic                  result_valid,
	input  wire                   result_ready,
	output logic [DEST_W-1:0]     dest_address,
	output logic [TEXEL_W-1:0]    texel_out,
	output logic                  last_of_image
);

	`include "texture_swizzle_address_gen_macros.svh"

	localparam int CW   = MAX_SIDE_LOG2;
	localparam int SL_W = $clog2(MAX_SIDE_LOG2 + 2);

	// Spread the bits of v to the even positions.
	function automatic logic [DEST_W-1:0] spread(input logic [CW-1:0] v);
		logic [DEST_W-1:0] r;
		r = '0;
		for (int i = 0; i < CW; i++) begin
			if (2 * i < DEST_W) begin
				r[2 * i] = v[i];
			end
		end
		return r;
	endfunction

	// Keep the bits of v below position n.
	function automatic logic [CW-1:0] low_bits(input logic [CW-1:0] v,
			input logic [SL_W-1:0] n);
		logic [CW-1:0] r;
		for (int i = 0; i < CW; i++) begin
			r[i] = v[i] & (i < int'(n));
		end
		return r;
	endfunction

	logic [LOG2_W-1:0] width_log2_q;
	logic [LOG2_W-1:0] height_log2_q;
	logic [BPT_W-1:0]  bytes_per_q;
	logic [CW-1:0]     column_count_q;
	logic [CW-1:0]     row_count_q;

	logic              valid_s1;
	logic [TEXEL_W-1:0] texel_s1;
	logic [CW-1:0]     col_s1;
	logic [CW-1:0]     row_s1;
	logic              last_s1;

	logic              valid_s2;
	logic [DEST_W-1:0] addr_s2;
	logic [TEXEL_W-1:0] texel_s2;
	logic              last_s2;

	logic [SL_W-1:0]   wl;
	logic [SL_W-1:0]   hl;
	logic [SL_W-1:0]   hl1;
	logic [BPT_W-1:0]  bpt;
	logic              in_take;
	logic              adv_s1;
	logic              col_wrap;
	logic              row_wrap;
	logic [CW:0]       col_edge;
	logic [CW:0]       row_edge;
	logic [DEST_W-1:0] sx;
	logic [DEST_W-1:0] sy;
	logic [DEST_W-1:0] addr_d;

	// Clamp the register values to their legal ranges
	always_comb begin
		wl  = (int'(width_log2_q) > MAX_SIDE_LOG2) ? SL_W'(MAX_SIDE_LOG2)
			: SL_W'(width_log2_q);
		hl  = (int'(height_log2_q) > MAX_SIDE_LOG2) ? SL_W'(MAX_SIDE_LOG2)
			: SL_W'(height_log2_q);
		hl1 = hl + SL_W'(1);
		if (bytes_per_q < BYTES_PER_MIN) begin
			bpt = BYTES_PER_MIN;
		end else if (bytes_per_q > BYTES_PER_MAX) begin
			bpt = BYTES_PER_MAX;
		end else begin
			bpt = bytes_per_q;
		end
	end

	// Handshake: the result register frees when taken, the input register when it moves
	assign adv_s1      = valid_s1 && (!valid_s2 || result_ready);
	assign texel_ready = !valid_s1 || adv_s1;
	assign in_take     = texel_valid && texel_ready;

	// Edge detection on the live counters
	assign col_edge = ((CW + 1)'(1) << wl) - (CW + 1)'(1);
	assign row_edge = ((CW + 1)'(1) << hl) - (CW + 1)'(1);
	assign col_wrap = {1'b0, column_count_q} >= col_edge;
	assign row_wrap = {1'b0, row_count_q} >= row_edge;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_log2_q  <= WIDTH_LOG2_RST;
			height_log2_q <= HEIGHT_LOG2_RST;
			bytes_per_q   <= BYTES_PER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH_LOG2:  width_log2_q  <= cfg_data[LOG2_W-1:0];
				REG_HEIGHT_LOG2: height_log2_q <= cfg_data[LOG2_W-1:0];
				REG_BYTES_PER:   bytes_per_q   <= cfg_data[BPT_W-1:0];
				default: ;
			endcase
		end
	end

	// Step the column on every taken word, and the row when the column wraps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (in_take) begin
			if (col_wrap) begin
				column_count_q <= '0;
				row_count_q    <= row_wrap ? '0 : row_count_q + CW'(1);
			end else begin
				column_count_q <= column_count_q + CW'(1);
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (texel_ready) begin
			valid_s1 <= texel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			texel_s1 <= texel_data;
			col_s1   <= column_count_q;
			row_s1   <= row_count_q;
			last_s1  <= col_wrap && row_wrap;
		end
	end

	// Swizzle: interleave folded coordinates and add the block offsets
	always_comb begin
		sy = (spread(low_bits(row_s1, wl)) << 1)
			+ (DEST_W'(row_s1 >> wl) << {wl, 1'b0});
		sx = spread(low_bits(col_s1, hl1))
			+ (DEST_W'(col_s1 >> hl1) << {hl, 1'b1});
		addr_d = (sx + sy) * DEST_W'(bpt);
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			addr_s2  <= addr_d;
			texel_s2 <= texel_s1;
			last_s2  <= last_s1;
		end
	end

	assign result_valid  = valid_s2;
	assign dest_address  = addr_s2;
	assign texel_out     = texel_s2;
	assign last_of_image = last_s2;

	// Checks
	`TSAG_ASSERT_SAME(a_take_into_free_slot, in_take, !valid_s1 || adv_s1,
		"input word taken over a held word")
	`TSAG_ASSERT_NEXT(a_move_fills_result, adv_s1, valid_s2,
		"word moved on but result register is empty")
	`TSAG_ASSERT_NEXT(a_last_clears_counters, in_take && col_wrap && row_wrap,
		column_count_q == '0 && row_count_q == '0,
		"counters not cleared after final texel")
	`TSAG_ASSERT_NEXT(a_column_steps, in_take && !col_wrap,
		column_count_q == $past(column_count_q) + CW'(1) && row_count_q == $past(row_count_q),
		"column did not step by one")

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import tsag_pkg::*;

	localparam int          SIDE_LOG2_CAP = 12;
	localparam logic [63:0] DEST_MASK     = 64'h3FF_FFFF;
	// Index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [DEST_W-1:0]  dest;
		logic [TEXEL_W-1:0] texel;
		logic               last;
	} swizzle_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  texel_valid = 1'b0;
	logic                  texel_ready;
	logic [TEXEL_W-1:0]    texel_data = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic [DEST_W-1:0]     dest_address;
	logic [TEXEL_W-1:0]    texel_out;
	logic                  last_of_image;

	// Register copies and raster position seen by the predictor
	logic [LOG2_W-1:0] width_log2_q  = WIDTH_LOG2_RST;
	logic [LOG2_W-1:0] height_log2_q = HEIGHT_LOG2_RST;
	logic [BPT_W-1:0]  bpt_q         = BYTES_PER_RST;
	logic [11:0]       column_q      = '0;
	logic [11:0]       row_q         = '0;

	logic [TEXEL_W-1:0] pending_texels[$];
	swizzle_word_t      swizzled_words[$];
	swizzle_word_t      oldest_word;

	int  failures = 0;
	int  texels_taken = 0;
	int  image_ends = 0;
	int  settings_used = 0;
	int  send_gap = 0;
	int  hold_gap = 0;
	bit  quiet = 1'b0;

	texture_swizzle_address_gen dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.texel_valid  (texel_valid),
		.texel_ready  (texel_ready),
		.texel_data   (texel_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.dest_address (dest_address),
		.texel_out    (texel_out),
		.last_of_image(last_of_image)
	);

	always #10 clk = ~clk;

	// Move the low 16 bits of v to the even bit positions
	function automatic logic [63:0] spread_even(input logic [63:0] v);
		logic [63:0] r;
		r = '0;
		for (int b = 0; b < 16; b++)
			r[2*b] = v[b];
		return r;
	endfunction

	// Swizzled address of the texel at the current position, then step the raster
	function automatic swizzle_word_t swizzle_texel(input logic [TEXEL_W-1:0] texel);
		swizzle_word_t res;
		int unsigned   wl, hl, bpt;
		logic [63:0]   x, y, w, h2, sx, sy;
		logic          col_wrap, row_wrap;
		wl  = (width_log2_q > SIDE_LOG2_CAP) ? SIDE_LOG2_CAP : 32'(width_log2_q);
		hl  = (height_log2_q > SIDE_LOG2_CAP) ? SIDE_LOG2_CAP : 32'(height_log2_q);
		bpt = 32'(bpt_q);
		if (bpt == 0)
			bpt = 1;
		if (bpt > 4)
			bpt = 4;
		x  = 64'(column_q);
		y  = 64'(row_q);
		w  = 64'd1 << wl;
		h2 = 64'd1 << (hl + 1);
		// Fold rows past the width into stacked square blocks
		if (y < w)
			sy = spread_even(y) << 1;
		else
			sy = (spread_even(y & (w - 1)) << 1) + ((y >> wl) << (2 * wl));
		// Fold columns past twice the height
		if (x < h2)
			sx = spread_even(x);
		else
			sx = spread_even(x & (h2 - 1)) + ((x >> (hl + 1)) << (2 * hl + 1));
		res.dest  = DEST_W'(((sx + sy) * bpt) & DEST_MASK);
		res.texel = texel;
		col_wrap  = (x >= w - 1);
		row_wrap  = (y >= (64'd1 << hl) - 1);
		res.last  = col_wrap && row_wrap;
		if (col_wrap) begin
			column_q = '0;
			row_q    = row_wrap ? 12'd0 : 12'(y + 1);
		end else begin
			column_q = 12'(x + 1);
		end
		return res;
	endfunction

	// Texel driver: predict on each accepted word, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			texel_valid <= 1'b0;
			texel_data  <= '0;
			send_gap = 0;
		end else begin
			if (texel_valid && texel_ready) begin
				swizzled_words.push_back(swizzle_texel(texel_data));
				texels_taken++;
			end
			if (!texel_valid || texel_ready) begin
				if (send_gap > 0 && !quiet) begin
					send_gap--;
					texel_valid <= 1'b0;
				end else if (pending_texels.size() > 0) begin
					texel_valid <= 1'b1;
					texel_data  <= pending_texels.pop_front();
					if (!quiet && $urandom_range(0, 7) == 0)
						send_gap = $urandom_range(1, 11);
				end else begin
					texel_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each accepted word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			hold_gap = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (swizzled_words.size() == 0) begin
					$error("result word with no texel pending: dest_address %h", dest_address);
					failures++;
				end else begin
					oldest_word = swizzled_words.pop_front();
					if (dest_address !== oldest_word.dest) begin
						$error("dest_address: expected %h, got %h", oldest_word.dest, dest_address);
						failures++;
					end
					if (texel_out !== oldest_word.texel) begin
						$error("texel_out: expected %h, got %h", oldest_word.texel, texel_out);
						failures++;
					end
					if (last_of_image !== oldest_word.last) begin
						$error("last_of_image: expected %b, got %b",
							oldest_word.last, last_of_image);
						failures++;
					end
					if (oldest_word.last)
						image_ends++;
				end
			end
			// Stall the result side in bursts
			if (hold_gap > 0 && !quiet) begin
				hold_gap--;
				result_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				hold_gap = $urandom_range(0, 10);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Write one register and mirror it
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_WIDTH_LOG2:  width_log2_q  = val;
			REG_HEIGHT_LOG2: height_log2_q = val;
			REG_BYTES_PER:   bpt_q         = val[BPT_W-1:0];
			default: ;
		endcase
	endtask

	// Write all three registers, then drop the enable
	task automatic set_config(input logic [CFG_DATA_W-1:0] wl, input logic [CFG_DATA_W-1:0] hl,
			input logic [CFG_DATA_W-1:0] bpt);
		cfg_write(REG_WIDTH_LOG2, wl);
		cfg_write(REG_HEIGHT_LOG2, hl);
		cfg_write(REG_BYTES_PER, bpt);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		settings_used++;
	endtask

	task automatic feed_random(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 15);
			if (pick == 0)
				pending_texels.push_back('0);
			else if (pick == 1)
				pending_texels.push_back('1);
			else
				pending_texels.push_back($urandom);
		end
	endtask

	// Hold until every texel is taken and every result word has come back
	task automatic drain();
		@(negedge clk);
		while (pending_texels.size() != 0 || texel_valid || swizzled_words.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int random_texels;
		int batch;
		logic [CFG_DATA_W-1:0] wl, hl, bpt;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// 1x1 image: every texel ends an image
		set_config(4'd0, 4'd0, 4'd1);
		pending_texels.push_back('0);
		pending_texels.push_back('1);
		pending_texels.push_back(32'hA5A5_A5A5);
		drain();

		// 2x2 image with a zero texel size
		set_config(4'd1, 4'd1, 4'd0);
		pending_texels.push_back(32'h0000_0001);
		pending_texels.push_back(32'h8000_0000);
		pending_texels.push_back(32'h5A5A_5A5A);
		pending_texels.push_back(32'hFFFF_FFFE);
		drain();

		// Wide 4x1 image with an oversized texel size
		set_config(4'd2, 4'd0, 4'hF);
		feed_random(4);
		drain();

		// Oversized width clamps to the cap; stop mid-row
		set_config(4'd15, 4'd0, 4'd3);
		feed_random(5);
		drain();

		// Shrink the width under the column already reached
		set_config(4'd1, 4'd13, 4'd4);
		feed_random(3);
		drain();

		// Write to the unused index, then a tall 1x2 image
		cfg_write(REG_UNUSED, 4'hF);
		set_config(4'd0, 4'd1, 4'd2);
		feed_random(2);
		drain();

		// Walk the row counter far down a one-texel-wide image
		set_config(4'd0, 4'd12, 4'd4);
		feed_random(160);
		drain();
		set_config(4'd12, 4'd12, 4'd4);
		feed_random(40);
		drain();
		random_texels = 200;

		// Random settings, mostly small images run through whole
		while (random_texels < 480) begin
			wl  = CFG_DATA_W'(($urandom_range(0, 9) == 0) ? $urandom_range(4, 15)
				: $urandom_range(0, 3));
			hl  = CFG_DATA_W'(($urandom_range(0, 9) == 0) ? $urandom_range(4, 15)
				: $urandom_range(0, 3));
			bpt = CFG_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
				: $urandom_range(1, 4));
			set_config(wl, hl, bpt);
			if (wl <= 3 && hl <= 3 && $urandom_range(0, 3) != 0)
				batch = (1 << (wl + hl)) * $urandom_range(1, 2);
			else
				batch = $urandom_range(1, 40);
			feed_random(batch);
			random_texels += batch;
			drain();
		end

		// Closing stretch at full rate on both sides
		quiet = 1'b1;
		set_config(4'd2, 4'd3, 4'd4);
		feed_random(64);
		drain();

		repeat (8) @(posedge clk);
		if (swizzled_words.size() != 0) begin
			$error("%0d result words never arrived", swizzled_words.size());
			failures++;
		end
		$display("Checked %0d texels over %0d register settings, %0d image ends seen.",
			texels_taken, settings_used, image_ends);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
